[rtl/qvr_pkg.sv]
// Shared constants and types for the quaternion vector rotation block.
package qvr_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 24;
  localparam int CW = 34;

  typedef logic signed [CW-1:0] cw_t;

  localparam cw_t GAIN_Q30 = cw_t'(652032874);

  localparam cw_t ATAN_TAB [CORDIC_STEPS_MAX] = '{
    cw_t'(536870912), cw_t'(316933406), cw_t'(167458907), cw_t'(85004756),
    cw_t'(42667331), cw_t'(21354465), cw_t'(10679838), cw_t'(5340245),
    cw_t'(2670163), cw_t'(1335087), cw_t'(667544), cw_t'(333772),
    cw_t'(166886), cw_t'(83443), cw_t'(41722), cw_t'(20861),
    cw_t'(10430), cw_t'(5215), cw_t'(2608), cw_t'(1304),
    cw_t'(652), cw_t'(326), cw_t'(163), cw_t'(81)
  };

endpackage

[rtl/qvr_cordic.sv]
// Unrolled rotation-mode CORDIC giving sine and cosine of a half angle.
module qvr_cordic #(
  parameter int STEPS = qvr_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [15:0] angle,
  output qvr_pkg::cw_t       sin_q30,
  output qvr_pkg::cw_t       cos_q30
);
  import qvr_pkg::*;

  cw_t x_r [0:STEPS];
  cw_t y_r [0:STEPS];
  cw_t z_r [0:STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= GAIN_Q30;
      y_r[0] <= '0;
      z_r[0] <= {{(CW-31){angle[15]}}, angle, 15'd0};
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    cw_t x_nxt, y_nxt, z_nxt;
    always_comb begin
      if (!z_r[i][CW-1]) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - ATAN_TAB[i];
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + ATAN_TAB[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
      end
    end
  end

  assign sin_q30 = y_r[STEPS];
  assign cos_q30 = x_r[STEPS];

endmodule

[rtl/euler_quaternion_vector_rotate.sv]
// Top level: Euler angles to quaternion and rotation of a vector.
// Throughput: one request per cycle; the whole pipeline holds while the
// result register is full and not taken.
// Reset: synchronous active-low rst_n clears all valid bits.
module euler_quaternion_vector_rotate #(
  parameter int CORDIC_STEPS = qvr_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pitch_angle, yaw_angle, roll_angle (16 each), vec_x, vec_y, vec_z (32 each)
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // quat_x, quat_y, quat_z, quat_w (16 each), rot_x, rot_y, rot_z (32 each)
  output logic [159:0] out_tdata
);
  import qvr_pkg::*;

  localparam int VD  = CORDIC_STEPS + 4;
  localparam int LAT = CORDIC_STEPS + 8;

  typedef logic signed [63:0] w_t;
  typedef logic signed [15:0] q_t;
  typedef logic signed [31:0] v_t;
  typedef logic signed [43:0] p_t;

  logic adv;
  logic [LAT-1:0] vld_r;

  assign adv        = !out_tvalid || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  cw_t sp, cp, sy, cy, sr, cr;

  qvr_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .adv(adv), .angle(in_tdata[15:0]), .sin_q30(sp), .cos_q30(cp));
  qvr_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .adv(adv), .angle(in_tdata[31:16]), .sin_q30(sy), .cos_q30(cy));
  qvr_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .adv(adv), .angle(in_tdata[47:32]), .sin_q30(sr), .cos_q30(cr));

  v_t vx_r [0:VD-1];
  v_t vy_r [0:VD-1];
  v_t vz_r [0:VD-1];
  cw_t sy_r, cy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r[0] <= in_tdata[79:48];
      vy_r[0] <= in_tdata[111:80];
      vz_r[0] <= in_tdata[143:112];
      for (int k = 1; k < VD; k++) begin
        vx_r[k] <= vx_r[k-1];
        vy_r[k] <= vy_r[k-1];
        vz_r[k] <= vz_r[k-1];
      end
    end
  end

  // pair products
  w_t m_crsp, m_crcp, m_srcp, m_srsp;
  cw_t crsp_r, crcp_r, srcp_r, srsp_r;
  assign m_crsp = w_t'(cr) * w_t'(sp);
  assign m_crcp = w_t'(cr) * w_t'(cp);
  assign m_srcp = w_t'(sr) * w_t'(cp);
  assign m_srsp = w_t'(sr) * w_t'(sp);

  function automatic w_t rnd(input w_t v, input int s);
    w_t h;
    h = w_t'(1) <<< (s - 1);
    return (v + h) >>> s;
  endfunction

  function automatic q_t sat16(input w_t v);
    if (v < -w_t'(32768)) return q_t'(-32768);
    if (v > w_t'(32767)) return q_t'(32767);
    return q_t'(v);
  endfunction

  function automatic v_t sat32(input w_t v);
    if (v < -w_t'(64'sd2147483648)) return v_t'(-64'sd2147483648);
    if (v > w_t'(64'sd2147483647)) return v_t'(64'sd2147483647);
    return v_t'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      crsp_r <= cw_t'(rnd(m_crsp, 30));
      crcp_r <= cw_t'(rnd(m_crcp, 30));
      srcp_r <= cw_t'(rnd(m_srcp, 30));
      srsp_r <= cw_t'(rnd(m_srsp, 30));
      sy_r   <= sy;
      cy_r   <= cy;
    end
  end

  // triple products
  w_t t_r [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      t_r[0] <= w_t'(crsp_r) * w_t'(sy_r);
      t_r[1] <= w_t'(srcp_r) * w_t'(cy_r);
      t_r[2] <= w_t'(crsp_r) * w_t'(cy_r);
      t_r[3] <= w_t'(srcp_r) * w_t'(sy_r);
      t_r[4] <= w_t'(crcp_r) * w_t'(sy_r);
      t_r[5] <= w_t'(srsp_r) * w_t'(cy_r);
      t_r[6] <= w_t'(crcp_r) * w_t'(cy_r);
      t_r[7] <= w_t'(srsp_r) * w_t'(sy_r);
    end
  end

  q_t qx_r, qy_r, qz_r, qw_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      qx_r <= sat16(rnd(t_r[0] - t_r[1], 46));
      qy_r <= sat16(rnd(-t_r[2] - t_r[3], 46));
      qz_r <= sat16(rnd(t_r[4] - t_r[5], 46));
      qw_r <= sat16(rnd(t_r[6] + t_r[7], 46));
    end
  end

  // q * v products
  w_t a_r [12];
  q_t q1x_r, q1y_r, q1z_r, q1w_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a_r[0]  <= w_t'(qx_r) * w_t'(vx_r[VD-1]);
      a_r[1]  <= w_t'(qy_r) * w_t'(vy_r[VD-1]);
      a_r[2]  <= w_t'(qz_r) * w_t'(vz_r[VD-1]);
      a_r[3]  <= w_t'(qw_r) * w_t'(vx_r[VD-1]);
      a_r[4]  <= w_t'(qy_r) * w_t'(vz_r[VD-1]);
      a_r[5]  <= w_t'(qz_r) * w_t'(vy_r[VD-1]);
      a_r[6]  <= w_t'(qw_r) * w_t'(vy_r[VD-1]);
      a_r[7]  <= w_t'(qz_r) * w_t'(vx_r[VD-1]);
      a_r[8]  <= w_t'(qx_r) * w_t'(vz_r[VD-1]);
      a_r[9]  <= w_t'(qw_r) * w_t'(vz_r[VD-1]);
      a_r[10] <= w_t'(qx_r) * w_t'(vy_r[VD-1]);
      a_r[11] <= w_t'(qy_r) * w_t'(vx_r[VD-1]);
      q1x_r <= qx_r;
      q1y_r <= qy_r;
      q1z_r <= qz_r;
      q1w_r <= qw_r;
    end
  end

  p_t pw_r, px_r, py_r, pz_r;
  q_t q2x_r, q2y_r, q2z_r, q2w_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pw_r <= p_t'(rnd(-(a_r[0] + a_r[1] + a_r[2]), 6));
      px_r <= p_t'(rnd(a_r[3] + a_r[4] - a_r[5], 6));
      py_r <= p_t'(rnd(a_r[6] + a_r[7] - a_r[8], 6));
      pz_r <= p_t'(rnd(a_r[9] + a_r[10] - a_r[11], 6));
      q2x_r <= q1x_r;
      q2y_r <= q1y_r;
      q2z_r <= q1z_r;
      q2w_r <= q1w_r;
    end
  end

  // (q * v) * conj(q) products
  w_t b_r [12];
  q_t q3x_r, q3y_r, q3z_r, q3w_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      b_r[0]  <= w_t'(pw_r) * w_t'(q2x_r);
      b_r[1]  <= w_t'(px_r) * w_t'(q2w_r);
      b_r[2]  <= w_t'(py_r) * w_t'(q2z_r);
      b_r[3]  <= w_t'(pz_r) * w_t'(q2y_r);
      b_r[4]  <= w_t'(pw_r) * w_t'(q2y_r);
      b_r[5]  <= w_t'(py_r) * w_t'(q2w_r);
      b_r[6]  <= w_t'(pz_r) * w_t'(q2x_r);
      b_r[7]  <= w_t'(px_r) * w_t'(q2z_r);
      b_r[8]  <= w_t'(pw_r) * w_t'(q2z_r);
      b_r[9]  <= w_t'(pz_r) * w_t'(q2w_r);
      b_r[10] <= w_t'(px_r) * w_t'(q2y_r);
      b_r[11] <= w_t'(py_r) * w_t'(q2x_r);
      q3x_r <= q2x_r;
      q3y_r <= q2y_r;
      q3z_r <= q2z_r;
      q3w_r <= q2w_r;
    end
  end

  v_t rx_r, ry_r, rz_r;
  q_t qox_r, qoy_r, qoz_r, qow_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      rx_r <= sat32(rnd(-b_r[0] + b_r[1] - b_r[2] + b_r[3], 22));
      ry_r <= sat32(rnd(-b_r[4] + b_r[5] - b_r[6] + b_r[7], 22));
      rz_r <= sat32(rnd(-b_r[8] + b_r[9] - b_r[10] + b_r[11], 22));
      qox_r <= q3x_r;
      qoy_r <= q3y_r;
      qoz_r <= q3z_r;
      qow_r <= q3w_r;
    end
  end

  assign out_tdata = {rz_r, ry_r, rx_r, qow_r, qoz_r, qoy_r, qox_r};

`ifndef NO_ASSERTIONS
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready does not follow output stall");
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted request lost at pipeline entry");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valid bits moved during stall");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[LAT-2]) |=> out_tvalid)
    else $error("result dropped at output stage");
`endif

endmodule
